[design/ffdc_pkg.sv]
// Shared constants and types for the fixed-length frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ffdc_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned CFG_IDX_W         = 1;

  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hA5;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h5A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD = 1'b0,
    REG_TAIL = 1'b1
  } cfg_reg_e;

  // Frame queue status seen by the top level and the back half.
  typedef struct packed {
    logic full;
    logic empty;
  } fq_status_t;

endpackage

`default_nettype wire

[design/ffdc_front.sv]
// Front half: byte window, running payload sum and frame match.
// Holds the head/tail registers. Depends on ffdc_pkg.
`default_nettype none

module ffdc_front import ffdc_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [BYTE_W-1:0]               cfg_wdata_i,
  input  wire logic                            byte_valid_i,
  input  wire logic [BYTE_W-1:0]               rx_byte_i,
  output logic                                 frame_valid_o,
  output logic [PAYLOAD_BYTES*BYTE_W-1:0]      frame_o
);

  localparam int unsigned FRAME_LEN = PAYLOAD_BYTES + 3;
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN);
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_LEN - 1);

  logic [BYTE_W-1:0] win_q [FRAME_LEN];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] head_q, tail_q;
  logic [BYTE_W-1:0] add_byte, drop_byte, sum_next;
  logic              window_full, match;

  // Newest byte sits at the top of the window; fill_q entries from the top are valid.
  // sum_q tracks the valid bytes in the payload slots.
  assign add_byte  = (fill_q >= FILL_W'(2)) ? win_q[PAYLOAD_BYTES+1] : '0;
  assign drop_byte = (fill_q == LAST_FILL) ? win_q[1] : '0;
  assign sum_next  = sum_q + add_byte - drop_byte;

  // Checked against the window as it stands after this byte shifts in.
  assign window_full = (fill_q == LAST_FILL);
  assign match = window_full && (win_q[1] == head_q) && (rx_byte_i == tail_q) &&
                 (sum_next == win_q[PAYLOAD_BYTES+2]);

  assign frame_valid_o = byte_valid_i && match;

  always_comb begin
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      frame_o[k*BYTE_W +: BYTE_W] = win_q[k+2];
    end
  end

  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    if (byte_valid_i) begin
      if (match) begin
        fill_d = '0;
        sum_d  = '0;
      end else begin
        fill_d = window_full ? LAST_FILL : fill_q + FILL_W'(1);
        sum_d  = sum_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      head_q <= HEAD_RESET;
      tail_q <= TAIL_RESET;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      if (cfg_we_i && cfg_idx_i == REG_HEAD) begin
        head_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_TAIL) begin
        tail_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[FRAME_LEN-1] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

[design/ffdc_fifo.sv]
// Two-entry frame queue between the front and back halves.
// Depends on ffdc_pkg for the status struct.
`default_nettype none

module ffdc_fifo import ffdc_pkg::*; #(
  parameter int unsigned WIDTH = PAYLOAD_BYTES_DEF * BYTE_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rdata_o,
  output fq_status_t            status_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_wr, do_rd;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_wr   = wr_i && !status_o.full;
  assign do_rd   = rd_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/ffdc_back.sv]
// Back half: unloads one frame at a time, one payload byte per pop.
// Depends on ffdc_pkg.
`default_nettype none

module ffdc_back import ffdc_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fq_status_t                      fq_status_i,
  input  wire logic [PAYLOAD_BYTES*BYTE_W-1:0] frame_i,
  output logic                                 fq_rd_o,
  input  wire logic                            pop_i,
  output logic                                 empty_o,
  output logic [BYTE_W-1:0]                    payload_byte_o,
  output logic [IDX_W-1:0]                     byte_index_o,
  output logic                                 last_byte_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  logic [PAYLOAD_BYTES*BYTE_W-1:0] frame_q;
  logic [IDX_W-1:0]                idx_q;
  logic                            valid_q;
  logic                            take, is_last, load;

  assign is_last = (idx_q == LAST_IDX);
  assign take    = valid_q && pop_i;
  assign load    = (!valid_q || (take && is_last)) && !fq_status_i.empty;
  assign fq_rd_o = load;

  assign empty_o        = !valid_q;
  assign payload_byte_o = frame_q[BYTE_W-1:0];
  assign byte_index_o   = idx_q;
  assign last_byte_o    = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      idx_q <= idx_q + IDX_W'(1);
      if (is_last) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Oldest payload byte always sits in the low byte.
  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end else if (take) begin
      frame_q <= frame_q >> BYTE_W;
    end
  end

endmodule

`default_nettype wire

[design/fixed_frame_deframer_checksum_top.sv]
// Fixed-length frame deframer with head, tail and payload checksum.
// Input side: push_i/full_o with rx_byte_i; one byte per request, one per
// cycle while full_o is low. Output side: empty_o/pop_i; each request is one
// payload byte with its index and a last-byte flag, oldest first.
// A frame is head, PAYLOAD_BYTES payload bytes, checksum (8-bit sum of the
// payload) and tail. The window slides one byte at a time until a frame
// matches; then it restarts empty, so frames never overlap.
// Path: a matching frame is written to the frame queue when its tail byte is
// taken, then loaded into the unload register once the back half is free; its
// first payload byte then shows on the output.
// One input byte per cycle while full_o is low; the back end emits one byte per
// cycle, so an unstalled receiver drains a frame before the next can complete.
// If the receiver stalls, up to two matched frames wait in the frame queue
// behind the one being unloaded; full_o rises only when that queue is full.
// Reset: window empty, queue empty, head = 0xA5, tail = 0x5A. Config writes
// (cfg_idx_i 0 = head, 1 = tail) take effect at the next edge.
// Depends on ffdc_pkg, ffdc_front, ffdc_fifo and ffdc_back.
`default_nettype none

module fixed_frame_deframer_checksum_top import ffdc_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_wdata_i,
  input  wire logic                 push_i,
  output logic                      full_o,
  input  wire logic [BYTE_W-1:0]    rx_byte_i,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output logic [BYTE_W-1:0]         payload_byte_o,
  output logic [IDX_W-1:0]          byte_index_o,
  output logic                      last_byte_o
);

  localparam int unsigned FRAME_W = PAYLOAD_BYTES * BYTE_W;

  fq_status_t       fq_status;
  logic             byte_valid;
  logic             frame_valid;
  logic [FRAME_W-1:0] frame_in, frame_out;
  logic             fq_rd;

  assign full_o     = fq_status.full;
  assign byte_valid = push_i && !fq_status.full;

  ffdc_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (byte_valid),
    .rx_byte_i    (rx_byte_i),
    .frame_valid_o(frame_valid),
    .frame_o      (frame_in)
  );

  ffdc_fifo #(
    .WIDTH(FRAME_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (frame_valid),
    .wdata_i (frame_in),
    .rd_i    (fq_rd),
    .rdata_o (frame_out),
    .status_o(fq_status)
  );

  ffdc_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fq_status_i   (fq_status),
    .frame_i       (frame_out),
    .fq_rd_o       (fq_rd),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .payload_byte_o(payload_byte_o),
    .byte_index_o  (byte_index_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

`default_nettype wire

[design/ffdc_checker.sv]
// Port-level checks for the deframer: byte index sequencing, last flag and stall hold.
// Depends on ffdc_pkg; bound to fixed_frame_deframer_checksum_top.
`default_nettype none

module ffdc_checker import ffdc_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty_o,
  input wire logic              pop_i,
  input wire logic [BYTE_W-1:0] payload_byte_o,
  input wire logic [IDX_W-1:0]  byte_index_o,
  input wire logic              last_byte_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  // Last flag marks exactly the final payload position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (last_byte_o == (byte_index_o == LAST_IDX)))
  else $error("last_byte_o disagrees with byte_index_o");

  // Within a frame the next byte follows right away with the next index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !last_byte_o) |=>
      (!empty_o && byte_index_o == $past(byte_index_o) + IDX_W'(1)))
  else $error("payload bytes of a frame not contiguous");

  // A new frame always starts at index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && last_byte_o) |=> (empty_o || byte_index_o == '0))
  else $error("frame does not start at index zero");

  // A waiting result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(payload_byte_o) && $stable(byte_index_o)))
  else $error("result changed while stalled");

endmodule

bind fixed_frame_deframer_checksum_top ffdc_checker #(
  .PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_ffdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .payload_byte_o(payload_byte_o),
  .byte_index_o  (byte_index_o),
  .last_byte_o   (last_byte_o)
);

`default_nettype wire

[bench/testbench.sv]
// Testbench for fixed_frame_deframer_checksum_top: a byte table, then random frames,
// noise and broken frames, checked against an in-bench deframer.
// Depends on ffdc_pkg and the block's RTL.
`default_nettype none

module testbench;
  import ffdc_pkg::*;

  localparam int unsigned PAYLOAD     = PAYLOAD_BYTES_DEF;
  localparam int unsigned FRAME_LEN   = PAYLOAD + 3;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_BYTES = 90;
  localparam int unsigned NUM_PHASES  = 5;
  localparam int unsigned PRESS_PHASE = 2;
  localparam int unsigned DIR_LEN     = 23;
  localparam int unsigned DIR_TYPED   = 11;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } beat_t;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL, FR_BAD_HEAD, FR_CUT, FR_NOISE} frame_kind_e;

  // Stray byte, good frame (alternating extremes), then a frame with a bad checksum.
  localparam logic [BYTE_W-1:0] DIR_BYTES [DIR_LEN] = '{
    8'h00, HEAD_RESET, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
    8'hFC, TAIL_RESET, HEAD_RESET, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
    8'h07, 8'h08, 8'h25, TAIL_RESET
  };
  localparam logic [BYTE_W-1:0] DIR_PAYLOAD [PAYLOAD] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;
  logic                 push_i;
  logic                 full_o;
  logic [BYTE_W-1:0]    rx_byte_i;
  logic                 empty_o;
  logic                 pop_i;
  logic [BYTE_W-1:0]    payload_byte_o;
  logic [IDX_W-1:0]     byte_index_o;
  logic                 last_byte_o;

  fixed_frame_deframer_checksum_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push_i, .full_o,
    .rx_byte_i, .empty_o, .pop_i, .payload_byte_o, .byte_index_o, .last_byte_o
  );

  // Deframer state mirrored in the bench
  logic [BYTE_W-1:0] win [FRAME_LEN];
  int unsigned       win_fill;
  logic [BYTE_W-1:0] head_cfg;
  logic [BYTE_W-1:0] tail_cfg;
  beat_t             frame_beats [PAYLOAD];
  beat_t             payload_exp [$];

  logic [BYTE_W-1:0] tx_bytes [$];
  bit                tx_idle_on;
  bit                rx_hold_req;
  int                mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Takes one byte into the window; n is the number of payload bytes released.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output int n);
    logic [BYTE_W-1:0] sum;
    n = 0;
    if (win_fill >= FRAME_LEN) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < FRAME_LEN) return;
    sum = '0;
    for (int k = 1; k <= PAYLOAD; k++) sum += win[k];
    if (win[0] == head_cfg && win[FRAME_LEN-1] == tail_cfg && sum == win[PAYLOAD+1]) begin
      for (int k = 0; k < PAYLOAD; k++) begin
        frame_beats[k].data = win[k+1];
        frame_beats[k].idx  = k[IDX_W-1:0];
        frame_beats[k].last = (k == PAYLOAD - 1);
      end
      n = PAYLOAD;
      win_fill = 0;
    end else begin
      for (int k = 0; k < FRAME_LEN - 1; k++) win[k] = win[k+1];
      win_fill = FRAME_LEN - 1;
    end
  endtask

  // One request on the input side; typed rows take the hand-written payload.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed);
    int    gap;
    int    n;
    beat_t beat;
    gap = tx_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    deframe_byte(b, n);
    if (typed) begin
      for (int k = 0; k < PAYLOAD; k++) begin
        beat.data = DIR_PAYLOAD[k];
        beat.idx  = k[IDX_W-1:0];
        beat.last = (k == PAYLOAD - 1);
        payload_exp.push_back(beat);
      end
    end else begin
      for (int k = 0; k < n; k++) payload_exp.push_back(frame_beats[k]);
    end
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_frame(input frame_kind_e kind);
    logic [BYTE_W-1:0] pay [PAYLOAD];
    logic [BYTE_W-1:0] sum;
    int                cut;
    sum = '0;
    for (int k = 0; k < PAYLOAD; k++) begin
      pay[k] = rand_byte();
      sum += pay[k];
    end
    case (kind)
      FR_NOISE: begin
        repeat ($urandom_range(1, 4))
          tx_bytes.push_back(($urandom_range(0, 3) == 0) ? head_cfg : rand_byte());
      end
      FR_CUT: begin
        cut = $urandom_range(1, FRAME_LEN - 2);
        tx_bytes.push_back(head_cfg);
        for (int k = 0; k < cut; k++) tx_bytes.push_back(rand_byte());
      end
      default: begin
        tx_bytes.push_back((kind == FR_BAD_HEAD) ?
                           head_cfg ^ 8'($urandom_range(1, 255)) : head_cfg);
        for (int k = 0; k < PAYLOAD; k++) tx_bytes.push_back(pay[k]);
        tx_bytes.push_back((kind == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
        tx_bytes.push_back((kind == FR_BAD_TAIL) ?
                           tail_cfg ^ 8'($urandom_range(1, 255)) : tail_cfg);
      end
    endcase
  endtask

  // Mostly good frames; the rest noise and broken frames.
  task automatic gen_phase(input int unsigned n);
    int r;
    while (tx_bytes.size() < n) begin
      r = $urandom_range(0, 15);
      if (r < 10)       add_frame(FR_GOOD);
      else if (r == 10) add_frame(FR_BAD_SUM);
      else if (r == 11) add_frame(FR_BAD_TAIL);
      else if (r == 12) add_frame(FR_BAD_HEAD);
      else if (r == 13) add_frame(FR_CUT);
      else              add_frame(FR_NOISE);
    end
  endtask

  task automatic wait_idle();
    while (payload_exp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_pair(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] t);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_HEAD;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_idx_i   <= REG_TAIL;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    head_cfg = h;
    tail_cfg = t;
  endtask

  // Receiver: random pops, one long hold-off on request from the sender side
  initial begin
    int    gap;
    int    left;
    bit    rx_idle_on;
    beat_t want;
    pop_i <= 1'b0;
    rx_idle_on = 1'b1;
    left = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (left == 0) begin
        rx_idle_on = 1'($urandom_range(0, 1));
        left = $urandom_range(20, 60);
      end
      left--;
      if (rx_hold_req) begin
        pop_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
          pop_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
      if (payload_exp.size() == 0) begin
        report_mismatch("request with nothing expected", int'(payload_byte_o), 0);
      end else begin
        want = payload_exp.pop_front();
        if (payload_byte_o !== want.data)
          report_mismatch("payload_byte", int'(payload_byte_o), int'(want.data));
        if (byte_index_o !== want.idx)
          report_mismatch("byte_index", int'(byte_index_o), int'(want.idx));
        if (last_byte_o !== want.last)
          report_mismatch("last_byte", int'(last_byte_o), int'(want.last));
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] h;
    logic [BYTE_W-1:0] t;
    rst_ni      <= 1'b0;
    push_i      <= 1'b0;
    rx_byte_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_HEAD;
    cfg_wdata_i <= '0;
    head_cfg = HEAD_RESET;
    tail_cfg = TAIL_RESET;
    win_fill = 0;
    tx_idle_on = 1'b1;
    rx_hold_req = 1'b0;
    mismatch_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run on the reset values of head and tail
    for (int i = 0; i < DIR_LEN; i++) send_byte(DIR_BYTES[i], i == DIR_TYPED);
    push_i <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin h = HEAD_RESET; t = TAIL_RESET; end
        1:       begin h = 8'h00;      t = 8'hFF;      end
        2:       begin h = 8'hFF;      t = 8'h00;      end
        3:       begin h = 8'h7E;      t = 8'h7E;      end
        default: begin
          h = 8'($urandom_range(0, 255));
          t = 8'($urandom_range(0, 255));
        end
      endcase
      wait_idle();
      cfg_pair(h, t);
      // Pressure phase: sender never idles while the receiver holds off
      tx_idle_on = (p == PRESS_PHASE) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_hold_req = (p == PRESS_PHASE);
      gen_phase(PHASE_BYTES);
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front(), 1'b0);
      push_i <= 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
design/ffdc_pkg.sv
design/ffdc_front.sv
design/ffdc_fifo.sv
design/ffdc_back.sv
design/fixed_frame_deframer_checksum_top.sv
design/ffdc_checker.sv
bench/testbench.sv
